// File: sv/rad_pkg.sv
// Shared constants, opcodes and table port types for the resource allocator.
package rad_pkg;
    localparam int NUM_RES  = 8;
    localparam int NUM_PROC = 8;
    localparam int CNT_W    = 4;
    localparam int RES_W    = $clog2(NUM_RES);
    localparam int PROC_W   = $clog2(NUM_PROC);
    localparam int ADDR_W   = PROC_W + RES_W;
    localparam int WORK_W   = CNT_W + PROC_W + 1;
    localparam logic [CNT_W-1:0] CMAX = {CNT_W{1'b1}};

    localparam logic [2:0] OP_REQ    = 3'd0;
    localparam logic [2:0] OP_RETRY  = 3'd1;
    localparam logic [2:0] OP_REL    = 3'd2;
    localparam logic [2:0] OP_KILL   = 3'd3;
    localparam logic [2:0] OP_DETECT = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_BAD_REL = 2'd2;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              clr_held;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  held;
        logic [CNT_W-1:0]  pend;
    } t_tbl_req;

    typedef struct packed {
        logic [CNT_W-1:0] held;
        logic [CNT_W-1:0] pend;
    } t_tbl_rsp;
endpackage

// File: sv/rad_tbl.sv
// Held and pending count memories, one entry per process and resource.
module rad_tbl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rad_pkg::t_tbl_req i_req,
    output rad_pkg::t_tbl_rsp o_rsp
);
    import rad_pkg::*;
    localparam int DEPTH = NUM_PROC * NUM_RES;

    logic [CNT_W-1:0] r_held_mem [DEPTH];
    logic [CNT_W-1:0] r_pend_mem [DEPTH];
    logic [DEPTH-1:0] r_held_vld;
    logic [DEPTH-1:0] r_pend_vld;
    t_tbl_rsp         r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_held_mem[i_req.addr] <= i_req.held;
            r_pend_mem[i_req.addr] <= i_req.pend;
        end
        if (i_req.rd_en) begin
            r_rsp.held <= r_held_vld[i_req.addr] ? r_held_mem[i_req.addr] : '0;
            r_rsp.pend <= r_pend_vld[i_req.addr] ? r_pend_mem[i_req.addr] : '0;
        end
    end

    // Entries not yet written since reset (or, for holdings, since a totals load) read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vld <= '0;
            r_pend_vld <= '0;
        end else begin
            if (i_req.clr_held) begin
                r_held_vld <= '0;
            end
            if (i_req.wr_en) begin
                r_held_vld[i_req.addr] <= 1'b1;
                r_pend_vld[i_req.addr] <= 1'b1;
            end
        end
    end

    assign o_rsp = r_rsp;
endmodule

// File: sv/rad_ctl.sv
// Operation sequencer: free counts, pending requests and the detection sweep.
module rad_ctl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_opcode,
    input  logic [2:0]                   i_process,
    input  logic [2:0]                   i_resource,
    input  logic [3:0]                   i_amount,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [31:0]                  i_cfg_data,
    output logic                         o_done,
    output logic                         o_granted,
    output logic [1:0]                   o_status,
    output logic                         o_deadlock_found,
    output logic [7:0]                   o_deadlocked_mask,
    output logic [2:0]                   o_victim,
    output logic [3:0]                   o_free_units,
    output rad_pkg::t_tbl_req            o_tbl_req,
    input  rad_pkg::t_tbl_rsp            i_tbl_rsp
);
    import rad_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_K_RD, S_K_UPD, S_D_SEL, S_D_RD, S_D_CHK, S_D_ADD,
        S_D_END, S_RESP
    } t_state;

    t_state              r_state;
    logic [2:0]          r_op;
    logic [PROC_W-1:0]   r_proc;
    logic [RES_W-1:0]    r_addr;
    logic [CNT_W-1:0]    r_amt;
    logic [CNT_W-1:0]    r_free [NUM_RES];
    logic [RES_W-1:0]    r_pres [NUM_PROC];
    logic [CNT_W-1:0]    r_pamt [NUM_PROC];
    logic [NUM_PROC-1:0] r_pvld;
    logic [WORK_W-1:0]   r_work [NUM_RES];
    logic [CNT_W-1:0]    r_hbuf [NUM_RES];
    logic [NUM_PROC-1:0] r_fin;
    logic                r_fits;
    logic                r_prog;
    logic [PROC_W-1:0]   r_sp;
    logic [RES_W-1:0]    r_sr;
    logic                r_granted;
    logic [1:0]          r_status;
    logic                r_found;
    logic [7:0]          r_mask;
    logic [2:0]          r_victim;

    logic [CNT_W:0]      pend_sum;
    logic [PROC_W-1:0]   lowest;
    logic [NUM_PROC-1:0] unfin;
    logic                last_proc;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done      = (r_state == S_RESP);
    assign unfin       = ~r_fin;
    assign last_proc   = (r_sp == PROC_W'(NUM_PROC - 1));
    assign pend_sum    = {1'b0, i_tbl_rsp.pend} + {1'b0, r_amt};

    always_comb begin
        lowest = '0;
        for (int i = NUM_PROC - 1; i >= 0; i--) begin
            if (unfin[i]) begin
                lowest = PROC_W'(i);
            end
        end
    end

    always_comb begin
        o_tbl_req          = '0;
        o_tbl_req.clr_held = (r_state == S_IDLE) && i_cfg_valid;
        case (r_state)
            S_IDLE: begin
                o_tbl_req.rd_en = start;
                o_tbl_req.addr  = {i_process,
                    (i_opcode == OP_RETRY && r_pvld[i_process]) ? r_pres[i_process] : i_resource};
            end
            S_EXEC: begin
                o_tbl_req.addr = {r_proc, r_addr};
                o_tbl_req.held = i_tbl_rsp.held;
                o_tbl_req.pend = i_tbl_rsp.pend;
                case (r_op)
                    OP_REQ: begin
                        o_tbl_req.wr_en = 1'b1;
                        if (r_free[r_addr] >= r_amt) begin
                            o_tbl_req.held = i_tbl_rsp.held + r_amt;
                        end else begin
                            o_tbl_req.pend = pend_sum[CNT_W] ? CMAX : pend_sum[CNT_W-1:0];
                        end
                    end
                    OP_RETRY: begin
                        if (r_pvld[r_proc] && r_free[r_addr] >= r_pamt[r_proc]) begin
                            o_tbl_req.wr_en = 1'b1;
                            o_tbl_req.held  = i_tbl_rsp.held + r_pamt[r_proc];
                            o_tbl_req.pend  = '0;
                        end
                    end
                    OP_REL: begin
                        if (r_amt <= i_tbl_rsp.held) begin
                            o_tbl_req.wr_en = 1'b1;
                            o_tbl_req.held  = i_tbl_rsp.held - r_amt;
                        end
                    end
                    default: ;
                endcase
            end
            S_K_RD, S_D_RD: begin
                o_tbl_req.rd_en = 1'b1;
                o_tbl_req.addr  = {r_sp, r_sr};
            end
            S_K_UPD: begin
                o_tbl_req.wr_en = 1'b1;
                o_tbl_req.addr  = {r_sp, r_sr};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pvld   <= '0;
            for (int i = 0; i < NUM_PROC; i++) begin
                r_pres[i] <= '0;
                r_pamt[i] <= '0;
            end
            for (int i = 0; i < NUM_RES; i++) begin
                r_free[i] <= CNT_W'(1);
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        for (int i = 0; i < NUM_RES; i++) begin
                            r_free[i] <= i_cfg_data[4*i +: CNT_W];
                        end
                    end
                    if (start) begin
                        r_op      <= i_opcode;
                        r_proc    <= i_process;
                        r_amt     <= i_amount;
                        r_addr    <= (i_opcode == OP_RETRY && r_pvld[i_process])
                                     ? r_pres[i_process] : i_resource;
                        r_granted <= 1'b0;
                        r_status  <= ST_OK;
                        r_found   <= 1'b0;
                        r_mask    <= '0;
                        r_victim  <= '0;
                        r_sp      <= i_process;
                        r_sr      <= '0;
                        if (i_opcode == OP_KILL) begin
                            r_state <= S_K_RD;
                        end else if (i_opcode == OP_DETECT) begin
                            for (int i = 0; i < NUM_RES; i++) begin
                                r_work[i] <= WORK_W'(r_free[i]);
                            end
                            r_fin   <= '0;
                            r_prog  <= 1'b0;
                            r_sp    <= '0;
                            r_state <= S_D_SEL;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        OP_REQ: begin
                            if (r_free[r_addr] >= r_amt) begin
                                r_free[r_addr] <= r_free[r_addr] - r_amt;
                                r_granted      <= 1'b1;
                            end else begin
                                r_pres[r_proc] <= r_addr;
                                r_pamt[r_proc] <= r_amt;
                                r_pvld[r_proc] <= 1'b1;
                                r_status       <= ST_PENDING;
                            end
                        end
                        OP_RETRY: begin
                            if (r_pvld[r_proc]) begin
                                if (r_free[r_addr] >= r_pamt[r_proc]) begin
                                    r_free[r_addr] <= r_free[r_addr] - r_pamt[r_proc];
                                    r_pvld[r_proc] <= 1'b0;
                                    r_pres[r_proc] <= '0;
                                    r_pamt[r_proc] <= '0;
                                    r_granted      <= 1'b1;
                                end else begin
                                    r_status <= ST_PENDING;
                                end
                            end
                        end
                        OP_REL: begin
                            if (r_amt > i_tbl_rsp.held) begin
                                r_status <= ST_BAD_REL;
                            end else begin
                                r_free[r_addr] <= r_free[r_addr] + r_amt;
                            end
                        end
                        default: ;
                    endcase
                    r_state <= S_RESP;
                end
                S_K_RD: begin
                    r_state <= S_K_UPD;
                end
                S_K_UPD: begin
                    // Return holdings of one resource; drop pending state after the last one.
                    r_free[r_sr] <= r_free[r_sr] + i_tbl_rsp.held;
                    if (r_sr == RES_W'(NUM_RES - 1)) begin
                        r_pvld[r_sp] <= 1'b0;
                        r_pres[r_sp] <= '0;
                        r_pamt[r_sp] <= '0;
                        r_state      <= S_RESP;
                    end else begin
                        r_sr    <= r_sr + 1'b1;
                        r_state <= S_K_RD;
                    end
                end
                S_D_SEL: begin
                    if (r_fin[r_sp]) begin
                        if (!last_proc) begin
                            r_sp <= r_sp + 1'b1;
                        end else if (r_prog) begin
                            r_sp   <= '0;
                            r_prog <= 1'b0;
                        end else begin
                            r_state <= S_D_END;
                        end
                    end else begin
                        r_sr    <= '0;
                        r_fits  <= 1'b1;
                        r_state <= S_D_RD;
                    end
                end
                S_D_RD: begin
                    r_state <= S_D_CHK;
                end
                S_D_CHK: begin
                    if (WORK_W'(i_tbl_rsp.pend) > r_work[r_sr]) begin
                        r_fits <= 1'b0;
                    end
                    r_hbuf[r_sr] <= i_tbl_rsp.held;
                    if (r_sr == RES_W'(NUM_RES - 1)) begin
                        r_state <= S_D_ADD;
                    end else begin
                        r_sr    <= r_sr + 1'b1;
                        r_state <= S_D_RD;
                    end
                end
                S_D_ADD: begin
                    if (r_fits) begin
                        for (int i = 0; i < NUM_RES; i++) begin
                            r_work[i] <= r_work[i] + WORK_W'(r_hbuf[i]);
                        end
                        r_fin[r_sp] <= 1'b1;
                    end
                    if (!last_proc) begin
                        r_sp    <= r_sp + 1'b1;
                        r_prog  <= r_prog | r_fits;
                        r_state <= S_D_SEL;
                    end else if (r_prog || r_fits) begin
                        r_sp    <= '0;
                        r_prog  <= 1'b0;
                        r_state <= S_D_SEL;
                    end else begin
                        r_state <= S_D_END;
                    end
                end
                S_D_END: begin
                    if (unfin != '0) begin
                        r_found  <= 1'b1;
                        r_mask   <= 8'(unfin);
                        r_victim <= 3'(lowest);
                        r_sp     <= lowest;
                        r_sr     <= '0;
                        r_state  <= S_K_RD;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_granted         = r_granted;
    assign o_status          = r_status;
    assign o_deadlock_found  = r_found;
    assign o_deadlocked_mask = r_mask;
    assign o_victim          = r_victim;
    assign o_free_units      = r_free[r_addr];

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("busy held after result");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("transfer not taken");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_PENDING || o_status == ST_BAD_REL))
        else $error("bad status code");
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_granted |-> o_status == ST_OK) else $error("grant with error status");
    a_victim_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_deadlock_found |-> o_deadlocked_mask[o_victim])
        else $error("victim not deadlocked");
endmodule

// File: sv/resource_allocator_deadlock_detector.sv
// Counted-resource allocator with deadlock detection and victim recovery.
// Request, retry and release go through an execute state to the o_done strobe; terminate reads
// and updates the holdings of each resource in turn. Detect takes up to 9 passes over the 8
// processes, checking the held and pending counts of every resource for each unfinished process
// and skipping finished ones, then closes or terminates a victim. Busy high until o_done.
// Results cannot be stalled. Synchronous active-low reset: totals 1 per resource, nothing held.
module resource_allocator_deadlock_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [2:0]  i_process,
    input  logic [2:0]  i_resource,
    input  logic [3:0]  i_amount,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic        o_granted,
    output logic [1:0]  o_status,
    output logic        o_deadlock_found,
    output logic [7:0]  o_deadlocked_mask,
    output logic [2:0]  o_victim,
    output logic [3:0]  o_free_units
);
    import rad_pkg::*;

    t_tbl_req tbl_req;
    t_tbl_rsp tbl_rsp;

    rad_ctl u_ctl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_process         (i_process),
        .i_resource        (i_resource),
        .i_amount          (i_amount),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_granted         (o_granted),
        .o_status          (o_status),
        .o_deadlock_found  (o_deadlock_found),
        .o_deadlocked_mask (o_deadlocked_mask),
        .o_victim          (o_victim),
        .o_free_units      (o_free_units),
        .o_tbl_req         (tbl_req),
        .i_tbl_rsp         (tbl_rsp)
    );

    rad_tbl u_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp)
    );
endmodule

// File: bench/tb_resource_allocator_deadlock_detector.sv
// Self-checking testbench for the resource allocator with deadlock detection.
`timescale 1ns / 1ps

module tb_resource_allocator_deadlock_detector;
    import rad_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam logic [2:0] OP_UNUSED_A = 3'd5;
    localparam logic [2:0] OP_UNUSED_B = 3'd6;
    localparam logic [2:0] OP_UNUSED_C = 3'd7;
    localparam logic [31:0] TOTALS_RESET = 32'h1111_1111;

    typedef struct packed {
        logic       granted;
        logic [1:0] status;
        logic       found;
        logic [7:0] mask;
        logic [2:0] victim;
        logic [3:0] free_units;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_opcode = '0;
    logic [2:0]  i_process = '0;
    logic [2:0]  i_resource = '0;
    logic [3:0]  i_amount = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        o_done;
    logic        o_granted;
    logic [1:0]  o_status;
    logic        o_deadlock_found;
    logic [7:0]  o_deadlocked_mask;
    logic [2:0]  o_victim;
    logic [3:0]  o_free_units;

    resource_allocator_deadlock_detector uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // allocator state mirror
    logic [3:0] free_cnt [8];
    logic [3:0] held_cnt [8][8];
    logic [3:0] pend_cnt [8][8];
    logic [2:0] pend_res [8];
    logic [3:0] pend_amt [8];
    logic       pend_vld [8];

    t_outcome expected_outcomes[$];
    int errors = 0;
    int items_sent = 0;
    int outcomes_seen = 0;
    int deadlocks_seen = 0;
    int cfg_writes = 0;
    int idle_pct = 0;
    int stall_cycles = 0;

    function automatic void load_totals(logic [31:0] totals);
        for (int r = 0; r < 8; r++) begin
            free_cnt[r] = totals[4*r +: 4];
            for (int p = 0; p < 8; p++) held_cnt[p][r] = '0;
        end
    endfunction

    function automatic void terminate_proc(int p);
        for (int r = 0; r < 8; r++) begin
            free_cnt[r] = free_cnt[r] + held_cnt[p][r];
            held_cnt[p][r] = '0;
            pend_cnt[p][r] = '0;
        end
        pend_vld[p] = 1'b0;
        pend_res[p] = '0;
        pend_amt[p] = '0;
    endfunction

    function automatic logic [7:0] stuck_processes();
        int  avail [8];
        bit  finished [8];
        bit  moved;
        bit  fits;
        logic [7:0] m;
        m = '0;
        for (int r = 0; r < 8; r++) avail[r] = free_cnt[r];
        for (int p = 0; p < 8; p++) finished[p] = 1'b0;
        moved = 1'b1;
        while (moved) begin
            moved = 1'b0;
            for (int p = 0; p < 8; p++) begin
                if (!finished[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < 8; r++)
                        if (pend_cnt[p][r] > avail[r]) fits = 1'b0;
                    if (fits) begin
                        finished[p] = 1'b1;
                        for (int r = 0; r < 8; r++) avail[r] += held_cnt[p][r];
                        moved = 1'b1;
                    end
                end
            end
        end
        for (int p = 0; p < 8; p++) if (!finished[p]) m[p] = 1'b1;
        return m;
    endfunction

    function automatic t_outcome allocate_step(logic [2:0] op, int p, int r, logic [3:0] amt);
        t_outcome o;
        int addr;
        int v;
        logic [4:0] sum;
        logic [7:0] m;
        o = '0;
        addr = r;
        case (op)
            OP_REQ: begin
                if (free_cnt[r] >= amt) begin
                    free_cnt[r] = free_cnt[r] - amt;
                    held_cnt[p][r] = held_cnt[p][r] + amt;
                    o.granted = 1'b1;
                end else begin
                    sum = {1'b0, pend_cnt[p][r]} + {1'b0, amt};
                    pend_cnt[p][r] = (sum > {1'b0, CMAX}) ? CMAX : sum[3:0];
                    pend_res[p] = 3'(r);
                    pend_amt[p] = amt;
                    pend_vld[p] = 1'b1;
                    o.status = ST_PENDING;
                end
            end
            OP_RETRY: begin
                if (pend_vld[p]) begin
                    addr = pend_res[p];
                    if (free_cnt[addr] >= pend_amt[p]) begin
                        free_cnt[addr] = free_cnt[addr] - pend_amt[p];
                        held_cnt[p][addr] = held_cnt[p][addr] + pend_amt[p];
                        pend_cnt[p][addr] = '0;
                        pend_vld[p] = 1'b0;
                        pend_res[p] = '0;
                        pend_amt[p] = '0;
                        o.granted = 1'b1;
                    end else begin
                        o.status = ST_PENDING;
                    end
                end
            end
            OP_REL: begin
                if (amt > held_cnt[p][r]) begin
                    o.status = ST_BAD_REL;
                end else begin
                    held_cnt[p][r] = held_cnt[p][r] - amt;
                    free_cnt[r] = free_cnt[r] + amt;
                end
            end
            OP_KILL: terminate_proc(p);
            OP_DETECT: begin
                m = stuck_processes();
                if (m != 0) begin
                    v = 0;
                    while (!m[v]) v++;
                    o.found = 1'b1;
                    o.mask = m;
                    o.victim = 3'(v);
                    terminate_proc(v);
                end
            end
            default: ;
        endcase
        o.free_units = free_cnt[addr];
        return o;
    endfunction

    // Send one operation; start stays high after the transfer so that
    // back-to-back items need no second assignment in the same step.
    task automatic send_op(logic [2:0] op, int p, int r, logic [3:0] amt);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_process <= 3'(p);
        i_resource <= 3'(r);
        i_amount <= amt;
        do @(posedge i_clk); while (busy);
        expected_outcomes.push_back(allocate_step(op, p, r, amt));
        items_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_totals(logic [31:0] totals);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= totals;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        load_totals(totals);
        cfg_writes++;
    endtask

    // Checker: every strobed result must match the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_done) begin
            outcomes_seen++;
            if (o_deadlock_found) deadlocks_seen++;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result, nothing predicted", $time);
                errors++;
            end else begin
                e = expected_outcomes.pop_front();
                if (o_granted !== e.granted) begin
                    $display("%0t: granted exp %0d got %0d", $time, e.granted, o_granted);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_deadlock_found !== e.found) begin
                    $display("%0t: deadlock_found exp %0d got %0d", $time, e.found,
                             o_deadlock_found);
                    errors++;
                end
                if (o_deadlocked_mask !== e.mask) begin
                    $display("%0t: deadlocked_mask exp %h got %h", $time, e.mask,
                             o_deadlocked_mask);
                    errors++;
                end
                if (o_victim !== e.victim) begin
                    $display("%0t: victim exp %0d got %0d", $time, e.victim, o_victim);
                    errors++;
                end
                if (o_free_units !== e.free_units) begin
                    $display("%0t: free_units exp %0d got %0d", $time, e.free_units,
                             o_free_units);
                    errors++;
                end
            end
        end
    end

    // Watchdog: abort when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        // extremes and grants
        send_op(OP_REQ, 0, 0, 4'd0);
        send_op(OP_REQ, 7, 7, 4'd1);
        send_op(OP_REQ, 7, 7, 4'd15);
        send_op(OP_REQ, 7, 7, 4'd15);
        send_op(OP_RETRY, 3, 0, 4'd0);
        send_op(OP_RETRY, 7, 0, 4'd0);
        send_op(OP_REL, 7, 7, 4'd15);
        send_op(OP_REL, 7, 7, 4'd1);
        send_op(OP_KILL, 7, 0, 4'd0);
        send_op(OP_DETECT, 0, 0, 4'd0);
        // cross wait between processes 0 and 1
        send_op(OP_REQ, 0, 0, 4'd1);
        send_op(OP_REQ, 1, 1, 4'd1);
        send_op(OP_REQ, 0, 1, 4'd1);
        send_op(OP_REQ, 1, 0, 4'd1);
        send_op(OP_DETECT, 5, 5, 4'd0);
        send_op(OP_RETRY, 1, 3, 4'd0);
        send_op(OP_KILL, 1, 0, 4'd0);
        send_op(OP_UNUSED_A, 2, 2, 4'd3);
        send_op(OP_UNUSED_B, 5, 5, 4'd10);
        send_op(OP_UNUSED_C, 7, 7, 4'd15);
        send_op(OP_DETECT, 0, 0, 4'd0);
    endtask

    task automatic test_totals_extremes();
        write_totals(32'h0000_0000);
        send_op(OP_REQ, 2, 3, 4'd0);
        send_op(OP_REQ, 2, 3, 4'd1);
        send_op(OP_DETECT, 0, 0, 4'd0);
        write_totals(32'hFFFF_FFFF);
        send_op(OP_REQ, 4, 5, 4'd15);
        send_op(OP_RETRY, 2, 0, 4'd0);
        send_op(OP_REL, 4, 5, 4'd15);
        write_totals(TOTALS_RESET);
    endtask

    task automatic send_random_op();
        logic [2:0] op;
        int sel;
        int p;
        int r;
        logic [3:0] amt;
        sel = $urandom_range(99);
        p = $urandom_range(7);
        r = $urandom_range(7);
        amt = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        if (sel < 36) op = OP_REQ;
        else if (sel < 56) op = OP_RETRY;
        else if (sel < 76) begin
            op = OP_REL;
            if ($urandom_range(4) != 0) amt = 4'($urandom_range(held_cnt[p][r]));
        end
        else if (sel < 83) op = OP_KILL;
        else if (sel < 95) op = OP_DETECT;
        else op = 3'($urandom_range(7, 5));
        send_op(op, p, r, amt);
    endtask

    task automatic test_random_phase(int pct, int count);
        idle_pct = pct;
        write_totals($urandom());
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) write_totals({4'($urandom_range(3)), 4'($urandom_range(3)),
                4'($urandom_range(3)), 4'($urandom_range(3)), 4'($urandom_range(3)),
                4'($urandom_range(3)), 4'($urandom_range(3)), 4'($urandom_range(3))}
                & 32'h3333_3333);
            send_random_op();
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < 8; r++) begin
            pend_res[r] = '0;
            pend_amt[r] = '0;
            pend_vld[r] = 1'b0;
            for (int p = 0; p < 8; p++) pend_cnt[p][r] = '0;
        end
        load_totals(TOTALS_RESET);

        test_directed();
        test_totals_extremes();
        test_random_phase(0, 350);
        test_random_phase(77, 350);
        test_random_phase(0, 350);
        test_random_phase(10, 350);

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d operations, %0d results, %0d deadlock reports, %0d totals writes",
                 items_sent, outcomes_seen, deadlocks_seen, cfg_writes);
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

// File: resource_allocator_deadlock_detector.f
sv/rad_pkg.sv
sv/rad_tbl.sv
sv/rad_ctl.sv
sv/resource_allocator_deadlock_detector.sv
bench/tb_resource_allocator_deadlock_detector.sv
